// ----- hdl/mbps_pkg.sv -----
// Shared types and constants for the masked byte pattern search block.
`default_nettype none
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 25;
    localparam int OFFSET_W    = 24;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0] MAX_BUFFER_LENGTH = CNT_W'(25'h1000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_CARE_MASK    = 2'd2,
        REG_PATTERN_LEN  = 2'd3
    } reg_index_t;

    typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

    typedef struct packed {
        byte_vec_t               pattern;
        logic [PATTERN_MAX-1:0]  care;
        logic [LEN_W-1:0]        length;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/mbps_cfg.sv -----
// Configuration registers and effective pattern length clamp.
`default_nettype none
module mbps_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output mbps_pkg::cfg_t                      cfg
);
    import mbps_pkg::*;

    logic [63:0]            pat_low_reg;
    logic [63:0]            pat_high_reg;
    logic [PATTERN_MAX-1:0] care_reg;
    logic [LEN_W-1:0]       len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= '0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata[63:0];
                REG_PATTERN_HIGH: pat_high_reg <= cfg_wdata[63:0];
                REG_CARE_MASK:    care_reg     <= cfg_wdata[PATTERN_MAX-1:0];
                REG_PATTERN_LEN:  len_reg      <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.pattern = {pat_high_reg, pat_low_reg};
        cfg.care    = care_reg;
        if (len_reg > LEN_W'(PATTERN_MAX)) begin
            cfg.length = LEN_W'(PATTERN_MAX);
        end else begin
            cfg.length = len_reg;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mbps_match.sv -----
// Masked compare of the byte window against the pattern.
`default_nettype none
module mbps_match (
    input  wire mbps_pkg::byte_vec_t window,
    input  wire mbps_pkg::cfg_t      cfg,
    output logic                     match
);
    import mbps_pkg::*;

    logic [PATTERN_MAX-1:0] miss;
    logic [LEN_W-1:0]       pos;

    // Pattern byte k lines up with window entry length-1-k (newest first).
    always_comb begin
        miss = '0;
        pos  = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pos = cfg.length - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < cfg.length) && cfg.care[k]
                    && (window[pos[IDX_W-1:0]] != cfg.pattern[k])) begin
                miss[k] = 1'b1;
            end
        end
        match = ~|miss;
    end

endmodule
`default_nettype wire

// ----- hdl/masked_byte_pattern_search.sv -----
// Top level: masked byte pattern search over a byte stream.
// Takes one byte item per cycle unless a held result stalls it; returns at
// most one result item per buffer: the start offset of the first match
// (m_tuser = 1) or, on the buffer's last byte, a no-match item (m_tuser = 0,
// offset 0). An accepted byte is loaded into the input register; once the
// result register is free, a single pass of 16 masked byte compares loads
// it, driving m_tvalid. Pattern length zero matches at offset 0 on the first
// byte; lengths above 16 act as 16. Bytes beyond 2^24 in one buffer are not
// searched. Configure only while idle.
`default_nettype none
module masked_byte_pattern_search (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // data_byte
    input  wire logic                            s_tlast,  // last_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mbps_pkg::OFFSET_W-1:0]        m_tdata,  // match_offset
    output logic                                 m_tuser   // found
);
    import mbps_pkg::*;

    cfg_t cfg;

    mbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // search state
    byte_vec_t        window_reg, window_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             done_reg, done_next;

    // result register
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic                out_found_reg, out_found_next;
    logic                res_valid;

    logic advance;
    logic active;
    logic match;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign active = !done_reg && (seen_reg < MAX_BUFFER_LENGTH);

    always_comb begin
        window_next = window_reg;
        if (active) begin
            window_next = {window_reg[PATTERN_MAX-2:0], in_data_reg};
        end
    end

    mbps_match u_match (
        .window (window_next),
        .cfg    (cfg),
        .match  (match)
    );

    always_comb begin
        seen_next       = seen_reg;
        done_next       = done_reg;
        res_valid       = 1'b0;
        out_found_next  = 1'b0;
        out_offset_next = '0;
        if (active) begin
            seen_next = seen_reg + CNT_W'(1);
            if (cfg.length == '0) begin
                done_next      = 1'b1;
                res_valid      = 1'b1;
                out_found_next = 1'b1;
            end else if ((seen_next >= CNT_W'(cfg.length)) && match) begin
                done_next       = 1'b1;
                res_valid       = 1'b1;
                out_found_next  = 1'b1;
                out_offset_next = OFFSET_W'(seen_next - CNT_W'(cfg.length));
            end
        end
        if (in_last_reg) begin
            if (!done_next) begin
                res_valid = 1'b1;
            end
            seen_next = '0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            done_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= res_valid;
                seen_reg      <= seen_next;
                done_reg      <= done_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            window_reg <= window_next;
            if (res_valid) begin
                out_offset_reg <= out_offset_next;
                out_found_reg  <= out_found_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

endmodule
`default_nettype wire

// ----- tb/tb_masked_byte_pattern_search.sv -----
// Testbench for masked_byte_pattern_search: random byte buffers checked against a scan predictor.
`timescale 1ns / 1ps
module tb_masked_byte_pattern_search;
    import mbps_pkg::*;

    localparam int RUN_LIMIT = 300000;

    typedef struct {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } scan_report_t;

    class match_tracker;
        logic [CFG_DATA_W-1:0] pat_low;
        logic [CFG_DATA_W-1:0] pat_high;
        logic [PATTERN_MAX-1:0] care;
        logic [LEN_W-1:0] plen;
        logic [7:0] window [PATTERN_MAX];
        int unsigned seen;
        bit done;
        scan_report_t pending_reports[$];
        int errors;

        function new();
            pat_low  = '0;
            pat_high = '0;
            care     = '0;
            plen     = '0;
            errors   = 0;
            rearm();
        endfunction

        function void rearm();
            foreach (window[i]) window[i] = 8'h00;
            seen = 0;
            done = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PATTERN_LOW:  pat_low  = value;
                REG_PATTERN_HIGH: pat_high = value;
                REG_CARE_MASK:    care     = value[PATTERN_MAX-1:0];
                REG_PATTERN_LEN:  plen     = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_len();
            return (plen > PATTERN_MAX) ? PATTERN_MAX : int'(plen);
        endfunction

        // notes one accepted item and queues the report it causes, if any
        function void take_byte(logic [7:0] data, logic last);
            int eff;
            bit hit;
            bit reported;
            logic [2*CFG_DATA_W-1:0] pat;
            scan_report_t rep;
            eff = eff_len();
            pat = {pat_high, pat_low};
            reported = 0;
            if (!done && seen < MAX_BUFFER_LENGTH) begin
                for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = data;
                seen++;
                hit = (seen >= eff);
                for (int k = 0; k < eff; k++)
                    if (care[k] && window[eff-1-k] != pat[8*k +: 8]) hit = 0;
                if (hit) begin
                    done = 1;
                    reported = 1;
                    rep.found = 1'b1;
                    rep.offset = (eff == 0) ? '0 : OFFSET_W'(seen - eff);
                    pending_reports.push_back(rep);
                end
            end
            if (last) begin
                if (!done && !reported) begin
                    rep.found = 1'b0;
                    rep.offset = '0;
                    pending_reports.push_back(rep);
                end
                rearm();
            end
        endfunction

        function void check_report(logic found, logic [OFFSET_W-1:0] offset);
            scan_report_t want;
            if (pending_reports.size() == 0) begin
                $error("unexpected item: found=%0b match_offset=%0d", found, offset);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0b, actual %0b", want.found, found);
                errors++;
            end
            if (offset !== want.offset) begin
                $error("match_offset: expected %0d, actual %0d", want.offset, offset);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OFFSET_W-1:0] m_tdata;
    logic m_tuser;

    match_tracker tracker = new();
    logic [7:0] frame_bytes[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int cycles = 0;

    masked_byte_pattern_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("tb_masked_byte_pattern_search: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.take_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) tracker.check_report(m_tuser, m_tdata);
    end

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_reg(idx, value);
    endtask

    task automatic apply_config(logic [63:0] low, logic [63:0] high, logic [15:0] care,
                                logic [4:0] len);
        write_reg(REG_PATTERN_LOW, low);
        write_reg(REG_PATTERN_HIGH, high);
        write_reg(REG_CARE_MASK, 64'(care));
        write_reg(REG_PATTERN_LEN, 64'(len));
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_bytes[i];
            s_tlast  <= (i == frame_bytes.size() - 1);
            do @(posedge aclk); while (!s_tready);
        end
    endtask

    // sender pauses until every report is in, then lets the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // half the bytes are drawn from the pattern to provoke near misses
    function automatic logic [7:0] noise_byte();
        logic [127:0] pat;
        pat = {tracker.pat_high, tracker.pat_low};
        if ($urandom_range(1)) return 8'($urandom);
        return pat[8*$urandom_range(PATTERN_MAX-1) +: 8];
    endfunction

    task automatic build_frame(int max_fill);
        int eff;
        logic [127:0] pat;
        eff = tracker.eff_len();
        pat = {tracker.pat_high, tracker.pat_low};
        frame_bytes.delete();
        if (eff > 0 && $urandom_range(99) < 70) begin
            repeat ($urandom_range(max_fill)) frame_bytes.push_back(noise_byte());
            for (int k = 0; k < eff; k++)
                frame_bytes.push_back(tracker.care[k] ? pat[8*k +: 8] : 8'($urandom));
            repeat ($urandom_range(max_fill / 2)) frame_bytes.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(1, max_fill)) frame_bytes.push_back(noise_byte());
        end
    endtask

    initial begin
        int sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero length after reset: hit at offset 0 on the first byte, rest ignored
        frame_bytes = '{8'h00, 8'hFF};
        send_frame();
        frame_bytes = '{8'hA5};
        send_frame();
        drain();

        // zero pattern: a window of zero bytes must not match before four bytes are in
        apply_config(64'h0, 64'h0, 16'hFFFF, 5'd4);
        frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7E};
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h00};
        send_frame();
        drain();

        // two-byte pattern, care bits above the length ignored, hit on the last byte
        apply_config(64'h0000_0000_0000_80FF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd2);
        frame_bytes = '{8'h11, 8'hFF, 8'h80};
        send_frame();
        frame_bytes = '{8'hFF, 8'h7F, 8'h80, 8'hFF, 8'h80};
        send_frame();
        drain();

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: apply_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd31);
                1: apply_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd16);
                2: apply_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd1);
                3: apply_config({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                                5'd0);
                4: apply_config('1, '1, 16'hFFFF, 5'd16);
                5: apply_config('0, '0, 16'($urandom), 5'd8);
                default: apply_config({$urandom, $urandom}, {$urandom, $urandom},
                                      16'($urandom), 5'($urandom_range(1, 20)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (p == 3) hold_requests <= hold_requests + 1;
            sent = 0;
            while (sent < 150) begin
                build_frame((p == 3) ? 4 : 24);
                send_frame();
                sent += frame_bytes.size();
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("tb_masked_byte_pattern_search: done, clean");
        else
            $display("tb_masked_byte_pattern_search: done, errors");
        $finish;
    end
endmodule
